// ===== design/mcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsg_pkg
// Shared types and constants for the motion command safety gate.
// ----------------------------------------------------------------------------
package mcsg_pkg;

    localparam int SPEED_W = 16;
    localparam int LIMIT_W = 15;
    localparam int RANGE_W = 16;
    localparam int TICK_W  = 8;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    localparam logic [LIMIT_W-1:0] SPEED_LIM_RST = LIMIT_W'(306);
    localparam logic [RANGE_W-1:0] SAFETY_RST    = RANGE_W'(500);
    localparam logic [RANGE_W-1:0] FLOOR_RST     = RANGE_W'(0);
    localparam logic [TICK_W-1:0]  TIMEOUT_RST   = TICK_W'(20);
    localparam logic [TICK_W-1:0]  IDLE_RST      = TICK_W'(255);

    typedef enum logic [1:0] {
        REQ_TELEOP = 2'd0,
        REQ_RANGE  = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_ESTOP  = 2'd3
    } t_req_type;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SPEED_LIM = 2'd0,
        CFG_SAFETY    = 2'd1,
        CFG_FLOOR     = 2'd2,
        CFG_TIMEOUT   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] speed_lim;
        logic [RANGE_W-1:0] safety_dist;
        logic [RANGE_W-1:0] range_floor;
        logic [TICK_W-1:0]  timeout;
    } t_cfg;

    typedef struct packed {
        t_req_type                  req_type;
        logic signed [SPEED_W-1:0]  lin_cmd;
        logic signed [SPEED_W-1:0]  ang_cmd;
        logic [RANGE_W-1:0]         range_mm;
        logic                       scan_last;
        logic                       estop_on;
    } t_item;

    typedef struct packed {
        logic signed [SPEED_W-1:0]  lin;
        logic signed [SPEED_W-1:0]  ang;
        logic                       pass;
        logic                       obstacle;
        logic                       stop;
    } t_gate;

endpackage

// ===== design/motion_command_safety_gate_unit.sv =====
// ----------------------------------------------------------------------------
// motion_command_safety_gate_unit
// Safety gate for drive commands: teleop hold, idle timeout, obstacle stop,
// speed clamp and e-stop.
// ----------------------------------------------------------------------------
//   channel   handshake                 payload
//   -------   -----------------------   ----------------------------------------
//   request   i_valid / o_ready         i_req_type, i_lin_cmd, i_ang_cmd,
//                                       i_range_mm, i_scan_last, i_estop_on
//   command   o_valid / i_ready         o_lin_out, o_ang_out,
//                                       o_drive_enable, o_obstacle_seen
//   config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One beat per cycle while no tick waits on a stalled command register; a control
// tick's command is loaded into the command register when the tick leaves the input register.
// Rate is set by the input register feeding the state update and command register.
// Synchronous active-low reset; no clearing pass, ready as soon as reset is released.
// A stalled command register holds ticks in the input register; other beats pass.
// ----------------------------------------------------------------------------
module motion_command_safety_gate_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_req_type,
    input  logic signed [mcsg_pkg::SPEED_W-1:0] i_lin_cmd,
    input  logic signed [mcsg_pkg::SPEED_W-1:0] i_ang_cmd,
    input  logic [mcsg_pkg::RANGE_W-1:0]        i_range_mm,
    input  logic                                i_scan_last,
    input  logic                                i_estop_on,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mcsg_pkg::SPEED_W-1:0] o_lin_out,
    output logic signed [mcsg_pkg::SPEED_W-1:0] o_ang_out,
    output logic                                o_drive_enable,
    output logic                                o_obstacle_seen,
    input  logic                                i_cfg_we,
    input  logic [mcsg_pkg::CIDX_W-1:0]         i_cfg_idx,
    input  logic [mcsg_pkg::CFG_W-1:0]          i_cfg_data
);
    import mcsg_pkg::*;

    logic  r_in_valid;
    t_item r_item;
    t_cfg  cfg;
    t_gate gate;
    logic  is_tick;
    logic  fire;
    logic  load;
    logic  out_valid;

    assign is_tick = (r_item.req_type == REQ_TICK);
    assign fire    = r_in_valid && (!is_tick || !out_valid || i_ready);
    assign load    = fire && is_tick;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.req_type  <= t_req_type'(i_req_type);
            r_item.lin_cmd   <= i_lin_cmd;
            r_item.ang_cmd   <= i_ang_cmd;
            r_item.range_mm  <= i_range_mm;
            r_item.scan_last <= i_scan_last;
            r_item.estop_on  <= i_estop_on;
        end
    end

    mcsg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mcsg_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_gate  (gate)
    );

    mcsg_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_gate          (gate),
        .i_speed_lim     (cfg.speed_lim),
        .i_ready         (i_ready),
        .o_valid         (out_valid),
        .o_lin_out       (o_lin_out),
        .o_ang_out       (o_ang_out),
        .o_drive_enable  (o_drive_enable),
        .o_obstacle_seen (o_obstacle_seen)
    );

    assign o_valid = out_valid;

endmodule

// ===== design/mcsg_cfg.sv =====
// ----------------------------------------------------------------------------
// mcsg_cfg
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
module mcsg_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mcsg_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [mcsg_pkg::CFG_W-1:0]  i_cfg_data,
    output mcsg_pkg::t_cfg              o_cfg
);
    import mcsg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_lim   <= SPEED_LIM_RST;
            r_cfg.safety_dist <= SAFETY_RST;
            r_cfg.range_floor <= FLOOR_RST;
            r_cfg.timeout     <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SPEED_LIM: r_cfg.speed_lim   <= i_cfg_data[LIMIT_W-1:0];
                CFG_SAFETY:    r_cfg.safety_dist <= i_cfg_data[RANGE_W-1:0];
                CFG_FLOOR:     r_cfg.range_floor <= i_cfg_data[RANGE_W-1:0];
                CFG_TIMEOUT:   r_cfg.timeout     <= i_cfg_data[TICK_W-1:0];
                default:       r_cfg             <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/mcsg_state.sv =====
// ----------------------------------------------------------------------------
// mcsg_state
// Held command, idle counter, scan accumulator, obstacle flag and stop latch.
// ----------------------------------------------------------------------------
module mcsg_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mcsg_pkg::t_item   i_item,
    input  mcsg_pkg::t_cfg    i_cfg,
    output mcsg_pkg::t_gate   o_gate
);
    import mcsg_pkg::*;

    logic signed [SPEED_W-1:0] r_held_lin;
    logic signed [SPEED_W-1:0] r_held_ang;
    logic [TICK_W-1:0]         r_idle;
    logic                      r_scan_hit;
    logic                      r_obstacle;
    logic                      r_stop;

    logic [TICK_W-1:0] n_idle;
    logic              hit;
    logic              acc;

    always_comb begin
        n_idle = (r_idle < i_cfg.timeout) ? r_idle + TICK_W'(1) : r_idle;
        hit    = (i_item.range_mm < i_cfg.safety_dist) &&
                 (i_item.range_mm > i_cfg.range_floor);
        acc    = r_scan_hit | hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lin <= '0;
            r_held_ang <= '0;
            r_idle     <= IDLE_RST;
            r_scan_hit <= 1'b0;
            r_obstacle <= 1'b0;
            r_stop     <= 1'b0;
        end else if (i_fire) begin
            unique case (i_item.req_type)
                REQ_TELEOP: begin
                    r_held_lin <= i_item.lin_cmd;
                    r_held_ang <= i_item.ang_cmd;
                    r_idle     <= '0;
                end
                REQ_RANGE: begin
                    if (i_item.scan_last) begin
                        r_obstacle <= acc;
                        r_scan_hit <= 1'b0;
                    end else begin
                        r_scan_hit <= acc;
                    end
                end
                REQ_TICK: begin
                    r_idle <= n_idle;
                end
                REQ_ESTOP: begin
                    r_stop <= i_item.estop_on;
                end
                default: begin
                    r_stop <= r_stop;
                end
            endcase
        end
    end

    always_comb begin
        o_gate.lin      = r_held_lin;
        o_gate.ang      = r_held_ang;
        o_gate.pass     = n_idle < i_cfg.timeout;
        o_gate.obstacle = r_obstacle;
        o_gate.stop     = r_stop;
    end

endmodule

// ===== design/mcsg_out.sv =====
// ----------------------------------------------------------------------------
// mcsg_out
// Gate, clamp and register the drive command; output beat register.
// ----------------------------------------------------------------------------
module mcsg_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  mcsg_pkg::t_gate                     i_gate,
    input  logic [mcsg_pkg::LIMIT_W-1:0]        i_speed_lim,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic signed [mcsg_pkg::SPEED_W-1:0] o_lin_out,
    output logic signed [mcsg_pkg::SPEED_W-1:0] o_ang_out,
    output logic                                o_drive_enable,
    output logic                                o_obstacle_seen
);
    import mcsg_pkg::*;

    logic                      r_valid;
    logic signed [SPEED_W-1:0] r_lin;
    logic signed [SPEED_W-1:0] r_ang;
    logic                      r_wheels;
    logic                      r_obstacle;

    logic signed [SPEED_W-1:0] n_lin;
    logic signed [SPEED_W-1:0] n_ang;
    logic signed [SPEED_W:0]   lin_x;
    logic signed [SPEED_W:0]   lim_p;
    logic signed [SPEED_W:0]   lim_n;

    always_comb begin
        lim_p = $signed({2'b00, i_speed_lim});
        lim_n = -lim_p;
        n_lin = i_gate.pass ? i_gate.lin : '0;
        n_ang = i_gate.pass ? i_gate.ang : '0;
        if (i_gate.obstacle && (n_lin > 0)) begin
            n_lin = '0;
        end
        lin_x = {n_lin[SPEED_W-1], n_lin};
        priority if (lin_x > lim_p) begin
            n_lin = lim_p[SPEED_W-1:0];
        end else if (lin_x < lim_n) begin
            n_lin = lim_n[SPEED_W-1:0];
        end else begin
            n_lin = n_lin;
        end
        if (i_gate.stop) begin
            n_lin = '0;
            n_ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lin      <= n_lin;
            r_ang      <= n_ang;
            r_wheels   <= ~i_gate.stop;
            r_obstacle <= i_gate.obstacle;
        end
    end

    assign o_valid         = r_valid;
    assign o_lin_out       = r_lin;
    assign o_ang_out       = r_ang;
    assign o_drive_enable  = r_wheels;
    assign o_obstacle_seen = r_obstacle;

endmodule
